/* rtl/page_frame_allocator_replacement_macros.svh */
// Assertion macros for the page frame allocator.
// Included by the datapath and the controller. Needs nothing else.
`ifndef PAGE_FRAME_ALLOCATOR_REPLACEMENT_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_REPLACEMENT_MACROS_SVH
`ifndef SYNTHESIS
`define PFAR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFAR_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFAR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/pfar_pkg.sv */
// Shared types and constants for the page frame allocator.
// No dependencies; used by the datapath, the controller and the top level.
`timescale 1ns / 1ps
package pfar_pkg;

	localparam int NUM_FRAMES_DEF = 32;
	localparam int LFSR_W = 16;
	localparam int LEAST_W = 24;
	localparam logic [LEAST_W-1:0] COUNT_ABOVE_ALL = 24'd9999999;
	localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_VICTIM_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 2'd1;

	typedef enum logic [2:0] {
		CMD_ALLOC  = 3'd0,
		CMD_FORCE  = 3'd1,
		CMD_FREE   = 3'd2,
		CMD_TEST   = 3'd3,
		CMD_SETCNT = 3'd4
	} cmd_e;

	typedef struct packed {
		logic [2:0]  command;
		logic [4:0]  frame_index;
		logic [7:0]  owner_id;
		logic [15:0] use_count;
	} req_t;

	typedef struct packed {
		logic [4:0] frame;
		logic       success;
		logic       allocated;
		logic [7:0] evicted_owner;
		logic       evicted_valid;
		logic [5:0] free_count;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan_free;
		logic scan_cnt;
		logic rand_step;
		logic mod_step;
		logic commit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] command;
		logic       free_zero;
		logic       lcount_mode;
		logic       free_hit;
		logic       cnt_done;
		logic       mod_last;
	} dp_stat_t;

endpackage

/* rtl/pfar_dp.sv */
// Datapath: frame table, use count and owner memories, LFSR, scan and modulo units.
// Depends on pfar_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "page_frame_allocator_replacement_macros.svh"
module pfar_dp #(
	parameter int NUM_FRAMES = pfar_pkg::NUM_FRAMES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [pfar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfar_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  pfar_pkg::req_t                      req_data,
	input  pfar_pkg::dp_cmd_t                   cmd,
	output pfar_pkg::dp_stat_t                  stat,
	output pfar_pkg::rsp_t                      rsp_data
);

	localparam int IDX_W  = $clog2(NUM_FRAMES);
	localparam int FREE_W = $clog2(NUM_FRAMES + 1);
	localparam int REM_W  = IDX_W + 1;
	localparam int PTR_W  = (IDX_W + 1 > 4) ? IDX_W + 1 : 4;
	localparam int LW     = pfar_pkg::LFSR_W;
	localparam int RECIP_SH = 24;
	localparam int PROD_W = LW + RECIP_SH;
	localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((1 << RECIP_SH) / NUM_FRAMES);
	localparam logic [1:0] MOD_QUOT = 2'd0;
	localparam logic [1:0] MOD_REM  = 2'd1;
	localparam logic [1:0] MOD_LAST = 2'd2;

	pfar_pkg::req_t req_q;
	pfar_pkg::rsp_t rsp_q, rsp_next;

	logic [NUM_FRAMES-1:0] used_q;
	logic [7:0]  owner_mem [NUM_FRAMES];
	logic [15:0] count_mem [NUM_FRAMES];
	logic [7:0]  owner_rd_q;
	logic [15:0] count_rd_s1;
	logic [IDX_W-1:0] addr_s1;
	logic cmp_v_s1;

	logic [FREE_W-1:0] free_q, free_next;
	logic victim_mode_q;
	logic [LW-1:0] lfsr_q, lfsr_step;
	logic [PTR_W-1:0] ptr_q;
	logic [IDX_W-1:0] ptr_idx, victim_q, idx;
	logic [pfar_pkg::LEAST_W-1:0] least_q;
	logic [REM_W-1:0] rem_q, rem_red;
	logic [PROD_W-1:0] quot_prod;
	logic [LW-1:0] quot_q, back_prod, rem_diff;
	logic ptr_end, cnt_win, in_range;
	logic used_set, used_clr, own_we, cnt_we;
	logic [IDX_W-1:0] used_addr, cnt_waddr;

	assign ptr_idx = ptr_q[IDX_W-1:0];
	assign ptr_end = (ptr_q == PTR_W'(NUM_FRAMES));
	assign idx = IDX_W'(req_q.frame_index);
	assign in_range = (32'(req_q.frame_index) < 32'(NUM_FRAMES));
	assign cnt_win = cmp_v_s1 && ({8'd0, count_rd_s1} < least_q);

	assign lfsr_step = {1'b0, lfsr_q[LW-1:1]} ^ (lfsr_q[0] ? pfar_pkg::LFSR_MASK : '0);

	// quotient by reciprocal multiply is low by at most one, so one correcting subtract
	assign quot_prod = PROD_W'(lfsr_q) * PROD_W'(RECIP);
	assign back_prod = quot_q * LW'(NUM_FRAMES);
	assign rem_diff = lfsr_q - back_prod;
	assign rem_red = (rem_q >= REM_W'(NUM_FRAMES)) ? rem_q - REM_W'(NUM_FRAMES) : rem_q;

	assign stat.command     = req_q.command;
	assign stat.free_zero   = (free_q == '0);
	assign stat.lcount_mode = victim_mode_q;
	assign stat.free_hit    = !used_q[ptr_idx];
	assign stat.cnt_done    = ptr_end && !cmp_v_s1;
	assign stat.mod_last    = (ptr_q[1:0] == MOD_LAST);

	always_comb begin
		rsp_next = '0;
		rsp_next.frame = req_q.frame_index;
		free_next = free_q;
		used_set = 1'b0;
		used_clr = 1'b0;
		used_addr = victim_q;
		own_we = 1'b0;
		cnt_we = 1'b0;
		cnt_waddr = victim_q;
		unique case (req_q.command)
			pfar_pkg::CMD_ALLOC: begin
				rsp_next.frame = '0;
				if (free_q != '0) begin
					used_set = 1'b1;
					own_we = 1'b1;
					cnt_we = 1'b1;
					free_next = free_q - FREE_W'(1);
					rsp_next.frame = 5'(victim_q);
					rsp_next.success = 1'b1;
				end
			end
			pfar_pkg::CMD_FORCE: begin
				if (used_q[victim_q]) begin
					rsp_next.evicted_valid = 1'b1;
					rsp_next.evicted_owner = owner_rd_q;
				end else begin
					used_set = 1'b1;
					free_next = free_q - FREE_W'(1);
				end
				own_we = 1'b1;
				cnt_we = 1'b1;
				rsp_next.frame = 5'(victim_q);
				rsp_next.success = 1'b1;
			end
			pfar_pkg::CMD_FREE: begin
				used_addr = idx;
				if (in_range) begin
					if (used_q[idx]) begin
						used_clr = 1'b1;
						free_next = free_q + FREE_W'(1);
					end
					rsp_next.success = 1'b1;
				end
			end
			pfar_pkg::CMD_TEST: begin
				if (in_range) begin
					rsp_next.allocated = used_q[idx];
					rsp_next.success = 1'b1;
				end
			end
			pfar_pkg::CMD_SETCNT: begin
				cnt_waddr = idx;
				if (in_range) begin
					cnt_we = 1'b1;
					rsp_next.success = 1'b1;
				end
			end
			default: begin
			end
		endcase
		rsp_next.free_count = 6'(free_next);
	end

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			free_q <= FREE_W'(NUM_FRAMES);
			victim_mode_q <= 1'b1;
			lfsr_q <= LW'(1);
			ptr_q <= '0;
			cmp_v_s1 <= 1'b0;
			rem_q <= '0;
		end else begin
			if (cfg_write && cfg_index == pfar_pkg::REG_VICTIM_MODE) begin
				victim_mode_q <= cfg_data[0];
			end
			if (cfg_write && cfg_index == pfar_pkg::REG_RANDOM_SEED) begin
				lfsr_q <= (cfg_data == '0) ? LW'(1) : cfg_data;
			end else if (cmd.rand_step) begin
				lfsr_q <= lfsr_step;
			end
			cmp_v_s1 <= cmd.scan_cnt && !ptr_end;
			if (cmd.load) begin
				ptr_q <= '0;
				rem_q <= '0;
			end else if (cmd.scan_free || cmd.mod_step || (cmd.scan_cnt && !ptr_end)) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			if (cmd.mod_step && ptr_q[1:0] == MOD_REM) begin
				rem_q <= rem_diff[REM_W-1:0];
			end
			if (cmd.commit) begin
				free_q <= free_next;
				if (used_set) begin
					used_q[used_addr] <= 1'b1;
				end
				if (used_clr) begin
					used_q[used_addr] <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_data;
			least_q <= pfar_pkg::COUNT_ABOVE_ALL;
		end else if (cnt_win) begin
			least_q <= {8'd0, count_rd_s1};
		end
		if (cmd.mod_step && ptr_q[1:0] == MOD_QUOT) begin
			quot_q <= quot_prod[PROD_W-1:RECIP_SH];
		end
		if (cmd.scan_free && stat.free_hit) begin
			victim_q <= ptr_idx;
		end else if (cnt_win) begin
			victim_q <= addr_s1;
		end else if (cmd.mod_step && ptr_q[1:0] == MOD_LAST) begin
			victim_q <= rem_red[IDX_W-1:0];
		end
		addr_s1 <= ptr_idx;
		if (cmd.commit) begin
			rsp_q <= rsp_next;
		end
	end

	// memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (cmd.commit && cnt_we) begin
			count_mem[cnt_waddr] <= req_q.use_count;
		end
		count_rd_s1 <= count_mem[ptr_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && own_we) begin
			owner_mem[victim_q] <= req_q.owner_id;
		end
		owner_rd_q <= owner_mem[victim_q];
	end

	assign rsp_data = rsp_q;

	`PFAR_ASSERT(a_free_tracks_marks, clk, arst_n, (free_q == FREE_W'(NUM_FRAMES - $countones(used_q))), "free count disagrees with used marks")
	`PFAR_ASSERT(a_rem_below_frames, clk, arst_n, ({1'b0, rem_q} < (REM_W + 1)'(2 * NUM_FRAMES)), "modulo remainder out of range")
	`PFAR_ASSERT(a_force_victim_in_range, clk, arst_n, ((cmd.commit && req_q.command == pfar_pkg::CMD_FORCE) |-> (32'(victim_q) < 32'(NUM_FRAMES))), "victim frame out of range")

endmodule

/* rtl/pfar_ctrl.sv */
// Controller: sequences decode, scans, victim draw and commit; owns the handshakes.
// Depends on pfar_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "page_frame_allocator_replacement_macros.svh"
module pfar_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  pfar_pkg::dp_stat_t stat,
	output pfar_pkg::dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_FREE   = 7'b0000100,
		S_CNT    = 7'b0001000,
		S_RAND   = 7'b0010000,
		S_MOD    = 7'b0100000,
		S_COMMIT = 7'b1000000
	} state_t;

	state_t state_q, state_next;
	logic rsp_valid_q;
	logic own_wait_q;
	logic out_free;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_next = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_next = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.command)
					pfar_pkg::CMD_ALLOC: begin
						state_next = stat.free_zero ? S_COMMIT : S_FREE;
					end
					pfar_pkg::CMD_FORCE: begin
						if (!stat.lcount_mode) begin
							state_next = S_RAND;
						end else begin
							state_next = stat.free_zero ? S_CNT : S_FREE;
						end
					end
					default: begin
						state_next = S_COMMIT;
					end
				endcase
			end
			S_FREE: begin
				cmd.scan_free = 1'b1;
				if (stat.free_hit) begin
					state_next = S_COMMIT;
				end
			end
			S_CNT: begin
				cmd.scan_cnt = 1'b1;
				if (stat.cnt_done) begin
					state_next = S_COMMIT;
				end
			end
			S_RAND: begin
				cmd.rand_step = 1'b1;
				state_next = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_next = S_COMMIT;
				end
			end
			S_COMMIT: begin
				// owner read is registered from the victim, so commit waits for it once the victim settles
				if (!own_wait_q && out_free) begin
					cmd.commit = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			own_wait_q <= 1'b0;
		end else begin
			state_q <= state_next;
			own_wait_q <= (state_q != S_COMMIT) && (state_next == S_COMMIT);
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`PFAR_ASSERT(a_accept_to_decode, clk, arst_n, (req_valid && req_ready) |=> (state_q == S_DECODE), "accepted word not decoded")
	`PFAR_ASSERT(a_commit_holds, clk, arst_n, (state_q == S_COMMIT && rsp_valid_q && !rsp_ready) |=> (state_q == S_COMMIT && rsp_valid_q), "commit overran a waiting result")
	`PFAR_ASSERT(a_no_early_commit, clk, arst_n, cmd.commit |-> $past(state_q == S_COMMIT), "commit without settle cycle")

endmodule

/* rtl/page_frame_allocator_replacement.sv */
// Page frame allocator with least-count or random replacement: top level.
// Depends on pfar_pkg, pfar_dp and pfar_ctrl.
//
//   channel   dir   handshake                word
//   req       in    req_valid / req_ready    pfar_pkg::req_t
//   rsp       out   rsp_valid / rsp_ready    pfar_pkg::rsp_t
//   cfg       in    cfg_write (no wait)      cfg_index, cfg_data
//
// Time from accept to result: free/test/set-count go straight from decode to commit; allocate
// is set by the one-frame-a-cycle scan of the used marks; forced least-count with no free
// frame by the scan through the use count memory read port; forced random by the
// reciprocal-multiply modulo of the LFSR. One word in flight; ready again after commit.
// A finished word waits in the output register while the next is accepted; commit stalls
// while it is still held. Reset clears all used marks at once; no clearing pass.
`timescale 1ns / 1ps
module page_frame_allocator_replacement #(
	parameter int NUM_FRAMES = pfar_pkg::NUM_FRAMES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  pfar_pkg::req_t                   req_data,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output pfar_pkg::rsp_t                   rsp_data,
	input  logic                             cfg_write,
	input  logic [pfar_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfar_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pfar_pkg::dp_cmd_t  cmd;
	pfar_pkg::dp_stat_t stat;

	pfar_dp #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req_data (req_data),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_data (rsp_data)
	);

	pfar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

endmodule
